// File: rtl/tanh_soft_clipper_assert.svh
// Assertion macros shared by the soft clipper RTL.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef TANH_SOFT_CLIPPER_ASSERT_SVH
`define TANH_SOFT_CLIPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tsc_pkg.sv
// Package for the soft clipper: field widths, fixed-point constants, register codes
// and the elaboration-time builder of the tanh table. Depends on nothing.
package tsc_pkg;

    localparam int GAIN_W     = 16;  // drive_gain width, unsigned Q4.12
    localparam int NORM_W     = 15;  // norm_gain width, unsigned Q3.12
    localparam int GAIN_FRAC  = 12;
    localparam int TAB_FRAC   = 30;  // table points are Q1.30
    localparam int TAB_W      = 31;
    localparam int FR_BITS    = 16;  // interpolation fraction bits
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TAB_W-1:0] TAB_ONE = TAB_W'(1) << TAB_FRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_GAIN = 1'b0,
        CFG_NORM_GAIN  = 1'b1
    } t_cfg_idx;

    // Restoring long division, used only while building constants.
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= b) begin
                rem    = rem - b;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table point k of n: tanh(8k/n) in Q1.30. e^(-16k/n) comes from a
    // Taylor series of e^(-z) at z = 16k/(64n), squared six times.
    function automatic logic [TAB_W-1:0] tanh_point(int unsigned k, int unsigned n);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        longint      sum;
        z    = udiv64(64'(k) << 29, 64'(n));
        term = 64'(1) << 31;
        sum  = longint'(term);
        for (int unsigned i = 1; i <= 14; i++) begin
            term = udiv64((term * z) >> 31, 64'(i));
            if (i[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        s = 64'(sum);
        for (int j = 0; j < 6; j++) begin
            s = (s * s + (64'(1) << 30)) >> 31;
        end
        if (s > (64'(1) << 31)) begin
            s = 64'(1) << 31;
        end
        num = (64'(1) << 31) - s;
        den = (64'(1) << 31) + s;
        q   = udiv64((num << 31) + den, den << 1);
        return q[TAB_W-1:0];
    endfunction

endpackage

// File: rtl/tsc_gain_stage.sv
// First pipeline stage of the soft clipper: magnitude of the sample times drive gain.
// Depends on tsc_pkg and the assertion macro header.
`include "tanh_soft_clipper_assert.svh"

module tsc_gain_stage
    import tsc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [GAIN_W-1:0]             i_drive,
    input  logic                          i_ready,
    output logic                          o_take,
    output logic                          o_valid,
    output logic [SAMPLE_BITS+GAIN_W-1:0] o_u_mag,
    output logic                          o_neg
);

    localparam int UW = SAMPLE_BITS + GAIN_W;

    logic                   r_vld;
    logic [UW-1:0]          r_u;
    logic                   r_neg;
    logic                   w_neg;
    logic [SAMPLE_BITS-1:0] w_mag;

    // The most negative sample has a magnitude that still fits unsigned.
    assign w_neg  = i_sample[SAMPLE_BITS-1];
    assign w_mag  = w_neg ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(unsigned'(i_sample)))
                          : SAMPLE_BITS'(unsigned'(i_sample));
    assign o_take = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_u   <= UW'(w_mag) * UW'(i_drive);
            r_neg <= w_neg;
        end
    end

    assign o_valid = r_vld;
    assign o_u_mag = r_u;
    assign o_neg   = r_neg;

    `TSC_ASSERT_NEXT(a_take_fills, i_clk, i_rst_n, i_valid && o_take, o_valid, "accepted sample lost")

endmodule

// File: rtl/tsc_tanh_interp.sv
// Three pipeline stages: tanh table lookup, interpolation products, rounded sum.
// Depends on tsc_pkg (table builder, widths) and the assertion macro header.
`include "tanh_soft_clipper_assert.svh"

module tsc_tanh_interp
    import tsc_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = 256,
    parameter int SAMPLE_BITS        = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [SAMPLE_BITS+GAIN_W-1:0] i_u_mag,
    input  logic                          i_neg,
    input  logic                          i_ready,
    output logic                          o_take,
    output logic                          o_valid,
    output logic [TAB_W-1:0]              o_y,
    output logic                          o_neg
);

    localparam int UW = SAMPLE_BITS + GAIN_W;
    localparam int PB = SAMPLE_BITS - 1 + GAIN_FRAC + 3;  // 8.0 in the scale of u
    localparam int IW = $clog2(TANH_TABLE_ENTRIES);
    localparam int SW = UW + IW + 1;
    localparam int PW = TAB_W + FR_BITS + 1;

    logic [TAB_W-1:0] w_tab [0:TANH_TABLE_ENTRIES];

    for (genvar k = 0; k <= TANH_TABLE_ENTRIES; k++) begin : g_tab
        localparam logic [TAB_W-1:0] POINT = tanh_point(k, TANH_TABLE_ENTRIES);
        assign w_tab[k] = POINT;
    end

    logic [2:0]         r_vld;
    logic [3:0]         w_rdy;
    logic [SW-1:0]      w_scaled;
    logic               w_sat;
    logic [IW-1:0]      w_idx;
    logic [IW:0]        w_i0;
    logic [IW:0]        w_i1;
    logic [FR_BITS:0]   w_wt;
    logic [PW:0]        w_sum;
    logic [TAB_W-1:0]   r_t0;
    logic [TAB_W-1:0]   r_t1;
    logic [FR_BITS-1:0] r_fr;
    logic [2:0]         r_sat;
    logic [2:0]         r_neg;
    logic [PW-1:0]      r_p0;
    logic [PW-1:0]      r_p1;
    logic [TAB_W-1:0]   r_y;

    // Stage readiness: a stage takes new data when empty or when it drains.
    assign w_rdy[3] = i_ready;
    for (genvar j = 0; j < 3; j++) begin : g_rdy
        assign w_rdy[j] = !r_vld[j] || w_rdy[j+1];
    end
    assign o_take = w_rdy[0];

    assign w_scaled = SW'(i_u_mag) * SW'(TANH_TABLE_ENTRIES);
    assign w_sat    = |i_u_mag[UW-1:PB];
    assign w_idx    = w_sat ? '0 : w_scaled[PB +: IW];
    assign w_i0     = {1'b0, w_idx};
    assign w_i1     = w_i0 + (IW+1)'(1);
    assign w_wt     = {1'b1, {FR_BITS{1'b0}}} - {1'b0, r_fr};
    assign w_sum    = (PW+1)'(r_p0) + (PW+1)'(r_p1) + ((PW+1)'(1) << (FR_BITS-1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_t0     <= w_tab[w_i0];
            r_t1     <= w_tab[w_i1];
            r_fr     <= w_scaled[PB-1 -: FR_BITS];
            r_sat[0] <= w_sat;
            r_neg[0] <= i_neg;
        end
        if (w_rdy[1]) begin
            r_p0     <= PW'(r_t0) * PW'(w_wt);
            r_p1     <= PW'(r_t1) * PW'(r_fr);
            r_sat[1] <= r_sat[0];
            r_neg[1] <= r_neg[0];
        end
        if (w_rdy[2]) begin
            r_y      <= r_sat[1] ? TAB_ONE : w_sum[FR_BITS +: TAB_W];
            r_sat[2] <= r_sat[1];
            r_neg[2] <= r_neg[1];
        end
    end

    assign o_valid = r_vld[2];
    assign o_y     = r_y;
    assign o_neg   = r_neg[2];

    `TSC_ASSERT_NOW(a_y_le_one, i_clk, i_rst_n, r_vld[2], r_y <= TAB_ONE, "tanh above one")
    `TSC_ASSERT_NOW(a_sat_one, i_clk, i_rst_n, r_vld[2] && r_sat[2], r_y == TAB_ONE, "saturated tanh not one")

endmodule

// File: rtl/tsc_out_stage.sv
// Last two pipeline stages: normalization multiply, then rounding, sign and saturation.
// Depends on tsc_pkg and the assertion macro header.
`include "tanh_soft_clipper_assert.svh"

module tsc_out_stage
    import tsc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [TAB_W-1:0]              i_y,
    input  logic                          i_neg,
    input  logic [NORM_W-1:0]             i_norm,
    input  logic                          i_ready,
    output logic                          o_take,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int PRW = TAB_W + NORM_W;
    localparam int OSH = TAB_FRAC + GAIN_FRAC - (SAMPLE_BITS - 1);
    localparam logic [PRW:0] NEG_LIM = (PRW+1)'(1) << (SAMPLE_BITS - 1);
    localparam logic [PRW:0] POS_LIM = NEG_LIM - (PRW+1)'(1);

    logic [1:0]             r_vld;
    logic [2:0]             w_rdy;
    logic [PRW-1:0]         r_prod;
    logic                   r_neg;
    logic [SAMPLE_BITS-1:0] r_out;
    logic                   r_out_neg;
    logic [PRW:0]           w_omag;
    logic [SAMPLE_BITS-1:0] w_res;

    assign w_rdy[2] = i_ready;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];
    assign o_take   = w_rdy[0];

    assign w_omag = ((PRW+1)'(r_prod) + ((PRW+1)'(1) << (OSH - 1))) >> OSH;

    // Negative results may reach one step further than positive ones.
    always_comb begin
        logic [PRW:0] mag;
        if (r_neg) begin
            mag   = (w_omag > NEG_LIM) ? NEG_LIM : w_omag;
            w_res = SAMPLE_BITS'(0) - mag[SAMPLE_BITS-1:0];
        end else begin
            mag   = (w_omag > POS_LIM) ? POS_LIM : w_omag;
            w_res = mag[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_prod <= PRW'(i_y) * PRW'(i_norm);
            r_neg  <= i_neg;
        end
        if (w_rdy[1]) begin
            r_out     <= w_res;
            r_out_neg <= r_neg;
        end
    end

    assign o_valid  = r_vld[1];
    assign o_sample = signed'(r_out);

    `TSC_ASSERT_NOW(a_pos_sign, i_clk, i_rst_n, r_vld[1] && !r_out_neg, !r_out[SAMPLE_BITS-1], "positive result wrapped negative")

endmodule

// File: rtl/tanh_soft_clipper.sv
// Soft clipper for signed fixed-point audio: each sample is scaled by drive_gain,
// shaped by an interpolated tanh table with odd symmetry, scaled by norm_gain and
// saturated. The block takes one sample per clock while it is not stalled and returns
// each result through six register stages: drive multiply, table lookup,
// interpolation products, interpolation sum, normalization multiply, and the
// rounding and saturation stage that doubles as the output register. Stalls on
// the output side fill bubbles first and only then push back on the input, so no
// sample is dropped or repeated. The two gain registers are written through a plain
// write port (index 0 for drive_gain, index 1 for norm_gain, norm_gain taking the low
// 15 data bits); they must only be written while no sample is in flight. Drive above
// the table range (|u| of 8.0 or more) gives a tanh of exactly one, that is full
// scale after normalization for a norm_gain of 1.0 or more. Depends on tsc_pkg,
// tsc_gain_stage, tsc_tanh_interp and tsc_out_stage.

module tanh_soft_clipper
    import tsc_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = 256,
    parameter int SAMPLE_BITS        = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int UW = SAMPLE_BITS + GAIN_W;

    logic [GAIN_W-1:0] r_drive_gain;
    logic [NORM_W-1:0] r_norm_gain;

    logic             w_gain_take;
    logic             w_gain_vld;
    logic [UW-1:0]    w_u_mag;
    logic             w_u_neg;
    logic             w_tanh_take;
    logic             w_tanh_vld;
    logic [TAB_W-1:0] w_y;
    logic             w_y_neg;
    logic             w_out_take;

    // Gain registers. A write to an index outside the list changes nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_gain <= GAIN_W'(4096);
            r_norm_gain  <= NORM_W'(5378);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DRIVE_GAIN: begin
                    r_drive_gain <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_NORM_GAIN: begin
                    r_norm_gain <= i_cfg_data[NORM_W-1:0];
                end
                default: begin
                    r_drive_gain <= r_drive_gain;
                end
            endcase
        end
    end

    // Stage one: |sample| times drive gain, with the sign carried alongside.
    tsc_gain_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_sample (i_sample_in),
        .i_drive  (r_drive_gain),
        .i_ready  (w_tanh_take),
        .o_take   (w_gain_take),
        .o_valid  (w_gain_vld),
        .o_u_mag  (w_u_mag),
        .o_neg    (w_u_neg)
    );

    // Stages two to four: table lookup and linear interpolation of tanh(|u|).
    tsc_tanh_interp #(
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES),
        .SAMPLE_BITS        (SAMPLE_BITS)
    ) u_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_gain_vld),
        .i_u_mag (w_u_mag),
        .i_neg   (w_u_neg),
        .i_ready (w_out_take),
        .o_take  (w_tanh_take),
        .o_valid (w_tanh_vld),
        .o_y     (w_y),
        .o_neg   (w_y_neg)
    );

    // Stages five and six: normalization, rounding, sign and saturation.
    tsc_out_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_tanh_vld),
        .i_y      (w_y),
        .i_neg    (w_y_neg),
        .i_norm   (r_norm_gain),
        .i_ready  (!i_stall),
        .o_take   (w_out_take),
        .o_valid  (o_valid),
        .o_sample (o_sample_out)
    );

    // The input side is held off only when every stage holds a sample.
    assign o_stall = !w_gain_take;

endmodule
